// File: rtl/pck_pkg.sv
package pck_pkg;

    // defaults for number format
    localparam int NUM_WIDTH_DEF = 64;
    localparam int FRAC_BITS_DEF = 32;

    // key codes
    localparam logic [2:0] KEY_NUM   = 3'd0;
    localparam logic [2:0] KEY_PLUS  = 3'd1;
    localparam logic [2:0] KEY_MINUS = 3'd2;
    localparam logic [2:0] KEY_MUL   = 3'd3;
    localparam logic [2:0] KEY_DIV   = 3'd4;
    localparam logic [2:0] KEY_EQ    = 3'd5;
    localparam logic [2:0] KEY_CLR   = 3'd6;
    localparam logic [2:0] KEY_NONE  = 3'd0;

    // last entry kind
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_NUM  = 2'd1;
    localparam logic [1:0] KIND_OP   = 2'd2;

    typedef struct packed {
        logic [2:0]         func;
        logic signed [63:0] operand;
    } in_word_t;

    typedef struct packed {
        logic               accepted;
        logic               div_zero_error;
        logic               saturated;
        logic signed [63:0] current_result;
    } out_word_t;

endpackage

// File: rtl/precedence_calculator_keys.sv
// channel | signals                      | word
// in      | in_valid, in_ready, in_data  | key: func, operand
// out     | out_valid, out_ready, out_data | accepted, flags, current_result
//
// one key at a time; an operator key that follows a multiply or divide
// runs the bit-serial shift-add / restoring unit that handles one bit per
// cycle, over NUM_WIDTH bits to multiply and NUM_WIDTH+FRAC_BITS bits to
// divide (Q32.32 by default).
// reset clears all calculator state and the output register.
// a new key is taken only once the previous result word has been taken.
module precedence_calculator_keys #(
    parameter int NUM_WIDTH = pck_pkg::NUM_WIDTH_DEF,
    parameter int FRAC_BITS = pck_pkg::FRAC_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  pck_pkg::in_word_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output pck_pkg::out_word_t out_data
);
    import pck_pkg::*;

    localparam int W  = NUM_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int SW = W + F;
    localparam int CW = $clog2(SW + 1);
    localparam logic [W-1:0] MAXU = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINU = {1'b1, {(W-1){1'b0}}};
    localparam logic [CW-1:0] MUL_LAST = CW'(W - 1);
    localparam logic [CW-1:0] DIV_LAST = CW'(SW - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_FIN,
        ST_RESP
    } state_t;

    state_t               state_reg;
    logic [1:0]           kind_reg;
    logic signed [W-1:0]  num_reg;
    logic [2:0]           op_reg;
    logic signed [W-1:0]  sum_reg;
    logic                 sum_valid_reg;
    logic signed [W-1:0]  term_reg;
    logic                 acc_flag_reg;
    logic                 dz_flag_reg;
    logic                 sat_flag_reg;
    logic [2:0]           func_reg;
    logic                 div_mode_reg;
    logic                 neg_reg;
    logic [W:0]           acc_reg;
    logic [SW-1:0]        sh_reg;
    logic [W-1:0]         q_reg;
    logic                 ovf_reg;
    logic [W-1:0]         dvs_reg;
    logic [CW-1:0]        cnt_reg;
    logic                 out_valid_reg;
    out_word_t            out_reg;

    function automatic logic [W-1:0] mag(input logic signed [W-1:0] a);
        mag = a[W-1] ? (W)'(-a) : a;
    endfunction

    function automatic logic signed [W-1:0] sat_neg(input logic signed [W-1:0] a);
        sat_neg = (a == MINU) ? MAXU : -a;
    endfunction

    function automatic logic signed [W-1:0] sat_add(input logic signed [W-1:0] a,
                                                    input logic signed [W-1:0] b);
        logic [W:0] s;
        s = {a[W-1], a} + {b[W-1], b};
        if (s[W] != s[W-1])
            sat_add = s[W] ? MINU : MAXU;
        else
            sat_add = s[W-1:0];
    endfunction

    // operand narrowed to the number width
    logic signed [W-1:0] in_num;
    assign in_num = in_data.operand[W-1:0];

    // bit-serial step
    logic [W:0]   mul_sum;
    logic [W:0]   div_rem;
    logic         div_ge;
    logic [W:0]   div_sub;
    assign mul_sum = acc_reg + (sh_reg[0] ? {1'b0, dvs_reg} : {(W+1){1'b0}});
    assign div_rem = {acc_reg[W-1:0], sh_reg[SW-1]};
    assign div_ge  = div_rem >= {1'b0, dvs_reg};
    assign div_sub = div_rem - {1'b0, dvs_reg};

    // rounding and clamping of the unit result
    logic [2*W-1:0]    prod;
    logic [2*W+F-1:0]  prod_ext;
    logic [W-1:0]      fin_lo;
    logic              fin_hi;
    logic [W-1:0]      fin_lim;
    logic              fin_sat;
    logic signed [W-1:0] fin_val;
    assign prod     = {acc_reg[W-1:0], q_reg};
    assign prod_ext = (2*W+F)'(prod);
    assign fin_lo   = div_mode_reg ? q_reg : prod_ext[SW-1:F];
    assign fin_hi   = div_mode_reg ? ovf_reg : (|(prod_ext >> SW));
    assign fin_lim  = neg_reg ? MINU : MAXU;
    assign fin_sat  = fin_hi || (fin_lo > fin_lim);
    assign fin_val  = fin_sat ? (neg_reg ? MINU : MAXU)
                              : (neg_reg ? (W)'(-fin_lo) : fin_lo);

    logic fin_expr;
    assign fin_expr = (func_reg == KEY_PLUS) || (func_reg == KEY_MINUS)
                      || (func_reg == KEY_EQ);

    assign in_ready  = (state_reg == ST_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // control, calculator state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            kind_reg      <= KIND_NONE;
            num_reg       <= '0;
            op_reg        <= KEY_NONE;
            sum_reg       <= '0;
            sum_valid_reg <= 1'b0;
            term_reg      <= '0;
            acc_flag_reg  <= 1'b0;
            dz_flag_reg   <= 1'b0;
            sat_flag_reg  <= 1'b0;
            func_reg      <= KEY_NONE;
            div_mode_reg  <= 1'b0;
            neg_reg       <= 1'b0;
            acc_reg       <= '0;
            sh_reg        <= '0;
            q_reg         <= '0;
            ovf_reg       <= 1'b0;
            dvs_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        acc_flag_reg <= 1'b0;
                        dz_flag_reg  <= 1'b0;
                        sat_flag_reg <= 1'b0;
                        func_reg     <= in_data.func;
                        state_reg    <= ST_RESP;
                        if (in_data.func == KEY_CLR)
                        begin
                            kind_reg      <= KIND_NONE;
                            num_reg       <= '0;
                            op_reg        <= KEY_NONE;
                            sum_reg       <= '0;
                            sum_valid_reg <= 1'b0;
                            term_reg      <= '0;
                            acc_flag_reg  <= 1'b1;
                        end
                        else if (in_data.func == KEY_NUM)
                        begin
                            if (kind_reg != KIND_NUM)
                            begin
                                kind_reg     <= KIND_NUM;
                                num_reg      <= in_num;
                                acc_flag_reg <= 1'b1;
                            end
                        end
                        else if (in_data.func <= KEY_EQ && kind_reg == KIND_NUM)
                        begin
                            logic expr;
                            logic commit;
                            expr = (in_data.func == KEY_PLUS) || (in_data.func == KEY_MINUS)
                                   || (in_data.func == KEY_EQ);
                            commit = 1'b1;
                            unique case (op_reg)
                                KEY_PLUS, KEY_MINUS:
                                begin
                                    if (expr)
                                    begin
                                        sum_reg <= sat_add(sum_valid_reg ? sum_reg : '0,
                                            (op_reg == KEY_MINUS) ? sat_neg(num_reg) : num_reg);
                                        sum_valid_reg <= 1'b1;
                                        term_reg      <= '0;
                                    end
                                    else
                                        term_reg <= (op_reg == KEY_MINUS) ? sat_neg(num_reg)
                                                                          : num_reg;
                                end
                                KEY_MUL, KEY_DIV:
                                begin
                                    if (op_reg == KEY_DIV && num_reg == '0)
                                    begin
                                        if (expr)
                                        begin
                                            dz_flag_reg <= 1'b1;
                                            commit = 1'b0;
                                        end
                                        else
                                        begin
                                            sat_flag_reg <= 1'b1;
                                            term_reg <= (term_reg == '0) ? '0 :
                                                (term_reg[W-1] ? MINU : MAXU);
                                        end
                                    end
                                    else
                                    begin
                                        // start the serial unit
                                        commit       = 1'b0;
                                        div_mode_reg <= (op_reg == KEY_DIV);
                                        neg_reg      <= term_reg[W-1] != num_reg[W-1];
                                        dvs_reg      <= mag(num_reg);
                                        acc_reg      <= '0;
                                        q_reg        <= '0;
                                        ovf_reg      <= 1'b0;
                                        cnt_reg      <= '0;
                                        sh_reg       <= (op_reg == KEY_DIV)
                                            ? (SW'(mag(term_reg)) << F) : SW'(mag(term_reg));
                                        state_reg    <= ST_CALC;
                                    end
                                end
                                default:
                                begin
                                    if (in_data.func == KEY_MUL || in_data.func == KEY_DIV)
                                    begin
                                        sum_reg       <= '0;
                                        sum_valid_reg <= 1'b0;
                                        term_reg      <= num_reg;
                                    end
                                    else if (in_data.func == KEY_EQ)
                                        term_reg <= num_reg;
                                    else
                                    begin
                                        sum_reg       <= num_reg;
                                        sum_valid_reg <= 1'b1;
                                        term_reg      <= '0;
                                    end
                                end
                            endcase
                            if (commit)
                            begin
                                op_reg       <= in_data.func;
                                kind_reg     <= KIND_OP;
                                acc_flag_reg <= 1'b1;
                            end
                        end
                    end
                end
                ST_CALC:
                begin
                    if (div_mode_reg)
                    begin
                        acc_reg <= div_ge ? div_sub : div_rem;
                        ovf_reg <= ovf_reg | q_reg[W-1];
                        q_reg   <= {q_reg[W-2:0], div_ge};
                        sh_reg  <= sh_reg << 1;
                    end
                    else
                    begin
                        acc_reg <= {1'b0, mul_sum[W:1]};
                        q_reg   <= {mul_sum[0], q_reg[W-1:1]};
                        sh_reg  <= sh_reg >> 1;
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == (div_mode_reg ? DIV_LAST : MUL_LAST))
                        state_reg <= ST_FIN;
                end
                ST_FIN:
                begin
                    sat_flag_reg <= fin_sat;
                    if (fin_expr)
                    begin
                        sum_reg       <= sat_add(sum_valid_reg ? sum_reg : '0, fin_val);
                        sum_valid_reg <= 1'b1;
                        term_reg      <= '0;
                    end
                    else
                        term_reg <= fin_val;
                    op_reg       <= func_reg;
                    kind_reg     <= KIND_OP;
                    acc_flag_reg <= 1'b1;
                    state_reg    <= ST_RESP;
                end
                ST_RESP:
                begin
                    out_reg.accepted       <= acc_flag_reg;
                    out_reg.div_zero_error <= dz_flag_reg;
                    out_reg.saturated      <= sat_flag_reg;
                    out_reg.current_result <= 64'(sum_valid_reg ? sum_reg : term_reg);
                    out_valid_reg          <= 1'b1;
                    state_reg              <= ST_IDLE;
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

`ifndef SYNTH
    // a refused division never reports as taken
    a_dz_not_acc: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.div_zero_error && out_data.accepted))
        else $error("div zero word marked accepted");

    // clamping only happens on a taken key
    a_sat_acc: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.saturated |-> out_data.accepted)
        else $error("saturated word not accepted");

    // serial unit never runs past its bit count
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CALC |-> cnt_reg <= DIV_LAST)
        else $error("serial counter overran");

    // finishing the unit always leads to a result word
    a_fin_resp: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FIN |=> state_reg == ST_RESP)
        else $error("finish did not respond");
`endif

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import pck_pkg::*;

    localparam logic [2:0]         KEY_UNUSED = 3'd7;
    localparam logic signed [63:0] Q_MAX = 64'sh7fff_ffff_ffff_ffff;
    localparam logic signed [63:0] Q_MIN = 64'sh8000_0000_0000_0000;
    localparam logic signed [63:0] Q_ONE = 64'sh0000_0001_0000_0000;
    localparam int                 CYCLE_LIMIT = 2000000;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_word_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_word_t out_data;

    precedence_calculator_keys dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    // clock
    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // calculator state mirror
    logic [1:0]         m_kind;
    logic signed [63:0] m_last_num;
    logic [2:0]         m_last_op;
    logic signed [63:0] m_sum;
    logic               m_sum_valid;
    logic signed [63:0] m_term;
    logic               m_clamped;

    out_word_t expected_words[$];
    int        error_count;
    int        rx_idle_pct;
    int        cycle_count;

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        error_count++;
    endtask

    function automatic logic [63:0] magnitude(input logic signed [63:0] a);
        return a < 0 ? 64'd0 - a : a;
    endfunction

    function automatic logic signed [63:0] clamp_q(input logic [127:0] q, input logic neg);
        logic [63:0] lim;
        lim = neg ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
        if (q[127:64] != 0 || q[63:0] > lim)
        begin
            m_clamped = 1'b1;
            return neg ? Q_MIN : Q_MAX;
        end
        return neg ? 64'd0 - q[63:0] : q[63:0];
    endfunction

    function automatic logic signed [63:0] add_sat(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        s = a + b;
        if (s > Q_MAX) return Q_MAX;
        if (s < Q_MIN) return Q_MIN;
        return s[63:0];
    endfunction

    function automatic logic signed [63:0] neg_sat(input logic signed [63:0] a);
        return a == Q_MIN ? Q_MAX : -a;
    endfunction

    function automatic logic signed [63:0] q_mul(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
        logic [127:0] p;
        p = {64'd0, magnitude(a)} * {64'd0, magnitude(b)};
        return clamp_q(p >> 32, (a < 0) != (b < 0));
    endfunction

    function automatic logic signed [63:0] q_div(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
        logic [127:0] q;
        q = ({64'd0, magnitude(a)} << 32) / {64'd0, magnitude(b)};
        return clamp_q(q, (a < 0) != (b < 0));
    endfunction

    function automatic void add_to_sum(input logic signed [63:0] v);
        m_sum = add_sat(m_sum_valid ? m_sum : 64'sd0, v);
        m_sum_valid = 1'b1;
    endfunction

    function automatic void clear_calc();
        m_kind = KIND_NONE;
        m_last_num = 0;
        m_last_op = KEY_NONE;
        m_sum = 0;
        m_sum_valid = 1'b0;
        m_term = 0;
    endfunction

    // applies one key to the mirror and returns the result word
    function automatic out_word_t calc_key_predict(input in_word_t k);
        out_word_t r;
        logic      acc;
        logic      dz;
        logic      chain;
        logic signed [63:0] n;
        logic signed [63:0] v;
        acc = 1'b0;
        dz = 1'b0;
        m_clamped = 1'b0;
        if (k.func == KEY_CLR)
        begin
            clear_calc();
            acc = 1'b1;
        end
        else if (k.func == KEY_NUM)
        begin
            if (m_kind != KIND_NUM)
            begin
                m_kind = KIND_NUM;
                m_last_num = k.operand;
                acc = 1'b1;
            end
        end
        else if (k.func <= KEY_EQ && m_kind == KIND_NUM)
        begin
            chain = (k.func == KEY_MUL || k.func == KEY_DIV);
            n = m_last_num;
            case (m_last_op)
                KEY_PLUS, KEY_MINUS:
                begin
                    v = (m_last_op == KEY_MINUS) ? neg_sat(n) : n;
                    if (!chain)
                    begin
                        add_to_sum(v);
                        m_term = 0;
                    end
                    else
                        m_term = v;
                end
                KEY_MUL:
                begin
                    if (!chain)
                    begin
                        add_to_sum(q_mul(m_term, n));
                        m_term = 0;
                    end
                    else
                        m_term = q_mul(m_term, n);
                end
                KEY_DIV:
                begin
                    if (!chain)
                    begin
                        if (n == 0)
                            dz = 1'b1;
                        else
                        begin
                            add_to_sum(q_div(m_term, n));
                            m_term = 0;
                        end
                    end
                    else if (n == 0)
                    begin
                        // divide by zero inside a term chain saturates by sign
                        m_clamped = 1'b1;
                        m_term = m_term > 0 ? Q_MAX : (m_term < 0 ? Q_MIN : 64'sd0);
                    end
                    else
                        m_term = q_div(m_term, n);
                end
                default:
                begin
                    if (chain)
                    begin
                        m_sum = 0;
                        m_sum_valid = 1'b0;
                        m_term = n;
                    end
                    else if (k.func == KEY_EQ)
                        m_term = n;
                    else
                    begin
                        m_sum = n;
                        m_sum_valid = 1'b1;
                        m_term = 0;
                    end
                end
            endcase
            if (!dz)
            begin
                m_last_op = k.func;
                m_kind = KIND_OP;
                acc = 1'b1;
            end
        end
        r.accepted = acc;
        r.div_zero_error = dz;
        r.saturated = m_clamped;
        r.current_result = m_sum_valid ? m_sum : m_term;
        return r;
    endfunction

    function automatic logic signed [63:0] pick_number();
        int sel;
        sel = $urandom_range(9);
        case (sel)
            0: return 64'sd0;
            1: return Q_MAX;
            2: return Q_MIN;
            3, 4: return {$urandom, $urandom};
            5: return {{32{1'b0}}, $urandom};
            default:
                return $signed({{32{1'b0}}, 32'($urandom_range(20))}) * 65536 * 65536
                       * ($urandom_range(1) ? 1 : -1) + $signed({32'd0, $urandom});
        endcase
    endfunction

    // drive one key word, with a random gap in front
    task automatic send_key(input in_word_t k, input int gap_pct, input logic typed,
                            input out_word_t typed_word);
        out_word_t p;
        int        gap;
        gap = 0;
        while ($urandom_range(99) < gap_pct && gap < 20)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= k;
        do
            @(posedge clk);
        while (!in_ready);
        p = calc_key_predict(k);
        expected_words.insert(expected_words.size(), typed ? typed_word : p);
    endtask

    // result checking and receiver stalls
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_words.size() == 0)
                    report_mismatch("result word with nothing expected");
                else
                begin
                    out_word_t e;
                    e = expected_words.pop_front();
                    if (out_data.accepted !== e.accepted)
                        report_mismatch($sformatf("accepted %b exp %b",
                                                  out_data.accepted, e.accepted));
                    if (out_data.div_zero_error !== e.div_zero_error)
                        report_mismatch($sformatf("div_zero_error %b exp %b",
                                                  out_data.div_zero_error, e.div_zero_error));
                    if (out_data.saturated !== e.saturated)
                        report_mismatch($sformatf("saturated %b exp %b",
                                                  out_data.saturated, e.saturated));
                    if (out_data.current_result !== e.current_result)
                        report_mismatch($sformatf("current_result %h exp %h",
                                                  out_data.current_result, e.current_result));
                end
            end
            out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
        else
            out_ready <= 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    typedef struct {
        logic [2:0]         func;
        logic signed [63:0] operand;
        logic               typed;
        out_word_t          word;
    } key_row_t;

    function automatic out_word_t ow(input logic a, input logic d, input logic s,
                                     input logic signed [63:0] v);
        out_word_t r;
        r.accepted = a;
        r.div_zero_error = d;
        r.saturated = s;
        r.current_result = v;
        return r;
    endfunction

    initial
    begin
        key_row_t  rows[$];
        in_word_t  k;
        int        phase_tx[3];
        int        phase_rx[3];
        int        waited;
        out_word_t none_word;

        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        rx_idle_pct = 0;
        none_word = '0;
        clear_calc();
        phase_tx = '{34, 86, 0};
        phase_rx = '{86, 34, 0};

        // directed keys: errors, extremes, every operator and special case
        rows = '{
            '{KEY_PLUS,   64'sd0,       1'b1, ow(0, 0, 0, 0)},
            '{KEY_UNUSED, 64'sd5,       1'b1, ow(0, 0, 0, 0)},
            '{KEY_NUM,    Q_ONE,        1'b1, ow(1, 0, 0, 0)},
            '{KEY_NUM,    64'sd5,       1'b1, ow(0, 0, 0, 0)},
            '{KEY_DIV,    64'sd0,       1'b1, ow(1, 0, 0, Q_ONE)},
            '{KEY_NUM,    64'sd0,       1'b1, ow(1, 0, 0, Q_ONE)},
            '{KEY_EQ,     64'sd0,       1'b1, ow(0, 1, 0, Q_ONE)},
            '{KEY_DIV,    64'sd0,       1'b1, ow(1, 0, 1, Q_MAX)},
            '{KEY_NUM,    Q_MAX,        1'b0, none_word},
            '{KEY_MUL,    64'sd0,       1'b0, none_word},
            '{KEY_NUM,    Q_MIN,        1'b0, none_word},
            '{KEY_EQ,     64'sd0,       1'b0, none_word},
            '{KEY_NUM,    Q_MIN,        1'b0, none_word},
            '{KEY_MINUS,  64'sd0,       1'b0, none_word},
            '{KEY_NUM,    Q_MIN,        1'b0, none_word},
            '{KEY_MINUS,  64'sd0,       1'b0, none_word},
            '{KEY_NUM,    -64'sd1,      1'b0, none_word},
            '{KEY_MUL,    64'sd0,       1'b0, none_word},
            '{KEY_NUM,    3 * Q_ONE,    1'b0, none_word},
            '{KEY_DIV,    64'sd0,       1'b0, none_word},
            '{KEY_NUM,    7,            1'b0, none_word},
            '{KEY_PLUS,   64'sd0,       1'b0, none_word},
            '{KEY_CLR,    64'sd0,       1'b1, ow(1, 0, 0, 0)},
            '{KEY_EQ,     64'sd0,       1'b1, ow(0, 0, 0, 0)}
        };

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        rx_idle_pct = phase_rx[0];

        foreach (rows[i])
        begin
            k.func = rows[i].func;
            k.operand = rows[i].operand;
            send_key(k, phase_tx[0], rows[i].typed, rows[i].word);
        end

        // random keys: mostly alternating number and operator sequences
        for (int ph = 0; ph < 3; ph++)
        begin
            rx_idle_pct = phase_rx[ph];
            for (int i = 0; i < 430; i++)
            begin
                int sel;
                sel = $urandom_range(99);
                if (sel < 8)
                begin
                    // noise: any key code, any operand
                    k.func = 3'($urandom_range(7));
                    k.operand = {$urandom, $urandom};
                end
                else if (sel < 11)
                begin
                    k.func = KEY_CLR;
                    k.operand = {$urandom, $urandom};
                end
                else if (m_kind != KIND_NUM)
                begin
                    k.func = KEY_NUM;
                    k.operand = pick_number();
                end
                else
                begin
                    k.func = 3'($urandom_range(KEY_EQ, KEY_PLUS));
                    k.operand = {$urandom, $urandom};
                end
                send_key(k, phase_tx[ph], 1'b0, none_word);
            end
        end

        in_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        waited = 0;
        while (waited < 200)
        begin
            @(posedge clk);
            waited++;
        end

        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
